@@ sv/smp_pkg.sv @@
// Shared types and constants for the streaming max pool block.
// No dependencies; imported by every module of the block.
`default_nettype none

package smp_pkg;

    // Default sizing of the column store and of the pooling step.
    localparam int SMP_MAX_PLANE = 128;
    localparam int SMP_MAX_STEP  = 8;

    // Payload widths fixed by the data format (Q8.8 pixels, Q7.8 results).
    localparam int PIX_W  = 16;
    localparam int POOL_W = 15;

    // Configuration register widths.
    localparam int SIZE_REG_W   = 8;
    localparam int STRIDE_REG_W = 4;
    localparam int WIDTH_REG_W  = 4;
    localparam int COUNT_REG_W  = 11;
    localparam int PLANE_IDX_W  = 10;
    localparam int MAX_PLANES   = 1024;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;

    localparam logic [CFG_IDX_W-1:0] CFG_PLANE_SIZE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POOL_STRIDE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_WIDTH = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PLANE_COUNT  = 2'd3;

    // Per-pixel control handed from the position counters to the memory stage.
    typedef struct packed {
        logic in_win;   // pixel lies inside a window
        logic first;    // first pixel of its window
        logic last;     // last pixel of its window: emit a result
        logic pend;     // result closes the plane
        logic lend;     // result closes the layer
    } t_ctl;

endpackage

`default_nettype wire

@@ sv/smp_pos.sv @@
// Configuration registers and raster position counters of the max pool block.
// Depends on smp_pkg.
`default_nettype none

module smp_pos #(
    parameter int MAX_PLANE = smp_pkg::SMP_MAX_PLANE,
    parameter int MAX_STEP  = smp_pkg::SMP_MAX_STEP
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [smp_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [smp_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                           i_advance,
    output logic [$clog2(MAX_PLANE)-1:0]        o_slot,
    output smp_pkg::t_ctl                       o_ctl
);
    import smp_pkg::*;

    localparam int IDX_W  = $clog2(MAX_PLANE);
    localparam int SIZE_W = $clog2(MAX_PLANE + 1);
    localparam int ST_W   = $clog2(MAX_STEP + 1);
    localparam int PH_W   = (MAX_STEP > 1) ? $clog2(MAX_STEP) : 1;

    logic [SIZE_REG_W-1:0]   r_plane_size;
    logic [STRIDE_REG_W-1:0] r_pool_stride;
    logic [WIDTH_REG_W-1:0]  r_window_width;
    logic [COUNT_REG_W-1:0]  r_plane_count;

    logic [IDX_W-1:0]       r_row_index, n_row_index;
    logic [IDX_W-1:0]       r_col_index, n_col_index;
    logic [PH_W-1:0]        r_row_phase, n_row_phase;
    logic [PH_W-1:0]        r_col_phase, n_col_phase;
    logic [IDX_W-1:0]       r_out_column, n_out_column;
    logic [PLANE_IDX_W-1:0] r_plane_index, n_plane_index;

    logic [SIZE_W-1:0]      w_size;
    logic [ST_W-1:0]        w_stride;
    logic [ST_W-1:0]        w_win;
    logic [COUNT_REG_W-1:0] w_planes;
    logic                   w_last_row, w_last_col, w_col_wrap, w_row_wrap;

    // Effective settings: zero acts as one; clamp at max, window at stride.
    always_comb begin
        if (r_plane_size == '0) begin
            w_size = SIZE_W'(1);
        end else if (int'(r_plane_size) > MAX_PLANE) begin
            w_size = SIZE_W'(MAX_PLANE);
        end else begin
            w_size = SIZE_W'(r_plane_size);
        end

        if (r_pool_stride == '0) begin
            w_stride = ST_W'(1);
        end else if (int'(r_pool_stride) > MAX_STEP) begin
            w_stride = ST_W'(MAX_STEP);
        end else begin
            w_stride = ST_W'(r_pool_stride);
        end

        if (r_window_width == '0) begin
            w_win = ST_W'(1);
        end else if (int'(r_window_width) > int'(w_stride)) begin
            w_win = w_stride;
        end else begin
            w_win = ST_W'(r_window_width);
        end

        if (r_plane_count == '0) begin
            w_planes = COUNT_REG_W'(1);
        end else if (int'(r_plane_count) > MAX_PLANES) begin
            w_planes = COUNT_REG_W'(MAX_PLANES);
        end else begin
            w_planes = r_plane_count;
        end
    end

    // Window flags for the pixel at the current position.
    always_comb begin
        w_col_wrap = (int'(r_col_index) + 1 >= int'(w_size));
        w_row_wrap = (int'(r_row_index) + 1 >= int'(w_size));
        w_last_row = (int'(r_row_phase) + 1 == int'(w_win)) || w_row_wrap;
        w_last_col = (int'(r_col_phase) + 1 == int'(w_win)) || w_col_wrap;

        o_ctl.in_win = (int'(r_row_phase) < int'(w_win)) && (int'(r_col_phase) < int'(w_win));
        o_ctl.first  = (r_row_phase == '0) && (r_col_phase == '0);
        o_ctl.last   = o_ctl.in_win && w_last_row && w_last_col;
        o_ctl.pend   = (int'(r_row_index) - int'(r_row_phase) + int'(w_stride) >= int'(w_size))
                    && (int'(r_col_index) - int'(r_col_phase) + int'(w_stride) >= int'(w_size));
        o_ctl.lend   = o_ctl.pend && (int'(r_plane_index) + 1 >= int'(w_planes));
        o_slot       = r_out_column;
    end

    // Raster advance.
    always_comb begin
        n_row_index   = r_row_index;
        n_col_index   = r_col_index;
        n_row_phase   = r_row_phase;
        n_col_phase   = r_col_phase;
        n_out_column  = r_out_column;
        n_plane_index = r_plane_index;
        if (w_col_wrap) begin
            n_col_index  = '0;
            n_col_phase  = '0;
            n_out_column = '0;
            if (w_row_wrap) begin
                n_row_index = '0;
                n_row_phase = '0;
                if (int'(r_plane_index) + 1 >= int'(w_planes)) begin
                    n_plane_index = '0;
                end else begin
                    n_plane_index = r_plane_index + PLANE_IDX_W'(1);
                end
            end else begin
                n_row_index = r_row_index + IDX_W'(1);
                if (int'(r_row_phase) + 1 >= int'(w_stride)) begin
                    n_row_phase = '0;
                end else begin
                    n_row_phase = r_row_phase + PH_W'(1);
                end
            end
        end else begin
            n_col_index = r_col_index + IDX_W'(1);
            if (int'(r_col_phase) + 1 >= int'(w_stride)) begin
                n_col_phase  = '0;
                n_out_column = r_out_column + IDX_W'(1);
            end else begin
                n_col_phase = r_col_phase + PH_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plane_size   <= SIZE_REG_W'(128);
            r_pool_stride  <= STRIDE_REG_W'(2);
            r_window_width <= WIDTH_REG_W'(2);
            r_plane_count  <= COUNT_REG_W'(1);
            r_row_index    <= '0;
            r_col_index    <= '0;
            r_row_phase    <= '0;
            r_col_phase    <= '0;
            r_out_column   <= '0;
            r_plane_index  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_PLANE_SIZE:   r_plane_size   <= i_cfg_data[SIZE_REG_W-1:0];
                CFG_POOL_STRIDE:  r_pool_stride  <= i_cfg_data[STRIDE_REG_W-1:0];
                CFG_WINDOW_WIDTH: r_window_width <= i_cfg_data[WIDTH_REG_W-1:0];
                CFG_PLANE_COUNT:  r_plane_count  <= i_cfg_data[COUNT_REG_W-1:0];
                default: ;
            endcase
            // Any register write restarts the layer.
            r_row_index   <= '0;
            r_col_index   <= '0;
            r_row_phase   <= '0;
            r_col_phase   <= '0;
            r_out_column  <= '0;
            r_plane_index <= '0;
        end else if (i_advance) begin
            r_row_index   <= n_row_index;
            r_col_index   <= n_col_index;
            r_row_phase   <= n_row_phase;
            r_col_phase   <= n_col_phase;
            r_out_column  <= n_out_column;
            r_plane_index <= n_plane_index;
        end
    end

endmodule

`default_nettype wire

@@ sv/smp_rmw.sv @@
// Column maximum store with its read-modify-write stage and write forwarding.
// Depends on smp_pkg.
`default_nettype none

module smp_rmw #(
    parameter int MAX_PLANE = smp_pkg::SMP_MAX_PLANE
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_accept,
    input  wire logic [smp_pkg::PIX_W-1:0]   i_pixel,
    input  wire logic [$clog2(MAX_PLANE)-1:0] i_slot,
    input  wire smp_pkg::t_ctl               i_ctl,
    input  wire logic                        i_go,
    output logic                             o_valid,
    output smp_pkg::t_ctl                    o_ctl,
    output logic [smp_pkg::POOL_W-1:0]       o_pooled
);
    import smp_pkg::*;

    localparam int ADDR_W = $clog2(MAX_PLANE);

    logic [POOL_W-1:0] r_mem [MAX_PLANE];
    logic [POOL_W-1:0] r_rd;
    logic [POOL_W-1:0] r_fwd_val;
    logic              r_fwd;
    logic              r_valid;
    t_ctl              r_ctl;
    logic [ADDR_W-1:0] r_slot;
    logic [POOL_W-1:0] r_pos;

    logic [POOL_W-1:0] w_old;
    logic [POOL_W-1:0] w_new;
    logic              w_wr;

    always_comb begin
        w_old = r_fwd ? r_fwd_val : r_rd;
        if (r_ctl.first || (r_pos > w_old)) begin
            w_new = r_pos;
        end else begin
            w_new = w_old;
        end
        w_wr     = r_valid && i_go && r_ctl.in_win;
        o_valid  = r_valid;
        o_ctl    = r_ctl;
        o_pooled = w_new;
    end

    // Memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_slot] <= w_new;
        end
        if (i_accept) begin
            r_rd <= r_mem[i_slot];
        end
    end

    // Stage register; a write to the entry being read lands too late, so forward it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_accept) begin
            r_valid <= 1'b1;
        end else if (i_go) begin
            r_valid <= 1'b0;
        end
        if (i_accept) begin
            r_ctl     <= i_ctl;
            r_slot    <= i_slot;
            r_pos     <= i_pixel[PIX_W-1] ? '0 : i_pixel[POOL_W-1:0];
            r_fwd     <= w_wr && (r_slot == i_slot);
            r_fwd_val <= w_new;
        end
    end

endmodule

`default_nettype wire

@@ sv/streaming_max_pool_top.sv @@
// Top level of the streaming max pool block: position counters, column store, output register.
// Depends on smp_pkg, smp_pos and smp_rmw.
//
// Usage:
//  - Pixels of square planes arrive in raster order on the input channel
//    (i_in_valid / o_in_stall / i_pixel); a transfer happens on a rising edge
//    with valid high and stall low. One pixel can be taken every cycle while o_in_stall is low.
//  - Pooled results leave on the output channel (o_out_valid / i_out_stall)
//    with o_pooled, o_plane_end and o_layer_end. A result is produced once the
//    last pixel of a window is transferred.
//  - A result passes the memory stage register and then the output register
//    after the transfer of the pixel that closes its window. Throughput is
//    one pixel per cycle while o_in_stall is low, set by the read-modify-write
//    of the column store (one registered read and one write per cycle,
//    same-entry hazards resolved by forwarding).
//  - Configuration is written through i_cfg_valid / o_cfg_ready while the
//    block is idle; every write restarts the layer at row 0, column 0, plane 0.
//  - Reset (synchronous, active low) restores default settings, clears the
//    counters and empties the pipeline. The column store needs no clearing:
//    each window's first pixel writes its entry before it is read.
//  - When the receiver stalls, the result holds in the output register. Pixels
//    that close no window keep flowing; once a window-closing pixel reaches the
//    memory stage it waits there and o_in_stall rises until the output drains.
`default_nettype none

module streaming_max_pool_top #(
    parameter int MAX_PLANE = smp_pkg::SMP_MAX_PLANE,
    parameter int MAX_STEP  = smp_pkg::SMP_MAX_STEP
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [smp_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [smp_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                           i_in_valid,
    output logic                                o_in_stall,
    input  wire logic [smp_pkg::PIX_W-1:0]      i_pixel,
    output logic                                o_out_valid,
    input  wire logic                           i_out_stall,
    output logic [smp_pkg::POOL_W-1:0]          o_pooled,
    output logic                                o_plane_end,
    output logic                                o_layer_end
);
    import smp_pkg::*;

    localparam int ADDR_W = $clog2(MAX_PLANE);

    logic              w_accept;
    logic              w_go;
    logic              w_cfg_we;
    logic [ADDR_W-1:0] w_slot;
    t_ctl              w_ctl;
    logic              w_s1_valid;
    t_ctl              w_s1_ctl;
    logic [POOL_W-1:0] w_s1_pooled;
    logic              w_s1_emit;

    logic              r_out_valid;
    logic [POOL_W-1:0] r_pooled;
    logic              r_plane_end;
    logic              r_layer_end;

    // Configuration is always taken; the user writes only while idle.
    assign o_cfg_ready = 1'b1;
    assign w_cfg_we    = i_cfg_valid && o_cfg_ready;

    // The memory stage moves on unless it holds a result and the output is full and stalled.
    assign w_s1_emit  = w_s1_valid && w_s1_ctl.last;
    assign w_go       = !w_s1_emit || !r_out_valid || !i_out_stall;
    assign o_in_stall = w_s1_valid && !w_go;
    assign w_accept   = i_in_valid && !o_in_stall;

    smp_pos #(
        .MAX_PLANE (MAX_PLANE),
        .MAX_STEP  (MAX_STEP)
    ) u_pos (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (w_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_advance   (w_accept),
        .o_slot      (w_slot),
        .o_ctl       (w_ctl)
    );

    smp_rmw #(
        .MAX_PLANE (MAX_PLANE)
    ) u_rmw (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_pixel  (i_pixel),
        .i_slot   (w_slot),
        .i_ctl    (w_ctl),
        .i_go     (w_go),
        .o_valid  (w_s1_valid),
        .o_ctl    (w_s1_ctl),
        .o_pooled (w_s1_pooled)
    );

    // Output register: load a finished window, drop it once transferred.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_s1_emit && w_go) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
        if (w_s1_emit && w_go) begin
            r_pooled    <= w_s1_pooled;
            r_plane_end <= w_s1_ctl.pend;
            r_layer_end <= w_s1_ctl.lend;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_pooled    = r_pooled;
    assign o_plane_end = r_plane_end;
    assign o_layer_end = r_layer_end;

endmodule

`default_nettype wire

@@ sv/smp_chk.sv @@
// Port-level checker for the streaming max pool block, bound to its top level.
// Depends on smp_pkg and streaming_max_pool_top.
`default_nettype none

module smp_chk (
    input wire logic                        i_clk,
    input wire logic                        i_rst_n,
    input wire logic                        i_in_valid,
    input wire logic                        o_in_stall,
    input wire logic                        o_out_valid,
    input wire logic                        i_out_stall,
    input wire logic [smp_pkg::POOL_W-1:0]  o_pooled,
    input wire logic                        o_plane_end,
    input wire logic                        o_layer_end
);
    import smp_pkg::*;

    // A held result keeps its value while the receiver stalls.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_pooled)
            && $stable(o_plane_end) && $stable(o_layer_end))
        else $error("output changed while stalled");

    // The end of the layer is always the end of a plane.
    a_layer_in_plane: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_layer_end |-> o_plane_end)
        else $error("layer end without plane end");

    // Input backpressure only arises from a full, stalled output.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled without output backpressure");

    // A new result must be preceded by a pixel transfer.
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(i_in_valid && !o_in_stall, 2))
        else $error("result without a matching pixel transfer");

endmodule

bind streaming_max_pool_top smp_chk u_smp_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_pooled    (o_pooled),
    .o_plane_end (o_plane_end),
    .o_layer_end (o_layer_end)
);

`default_nettype wire
